>>> rtl/skf_pkg.sv
// Shared constants for the scalar Kalman filter.
package skf_pkg;

    // Fraction bits of estimate, covariance and noise values.
    localparam int FRAC_BITS = 16;
    // Fraction bits of the gain; the gain is Q1.16 whatever FRAC_BITS is.
    localparam int GAIN_BITS = 16;

    localparam int DATA_W = 32;
    localparam int GAIN_W = GAIN_BITS + 1;
    localparam int CFG_IDX_W = 4;

    typedef logic [DATA_W-1:0]        t_uval;
    typedef logic signed [DATA_W-1:0] t_sval;
    typedef logic [GAIN_W-1:0]        t_gain;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // Register indexes on the configuration port.
    localparam t_cfg_idx REG_PROCESS_NOISE      = 4'd0;
    localparam t_cfg_idx REG_MEASUREMENT_NOISE  = 4'd1;
    localparam t_cfg_idx REG_INITIAL_ESTIMATE   = 4'd2;
    localparam t_cfg_idx REG_INITIAL_COVARIANCE = 4'd3;

    // Reset values: q = 0.1 rounded to nearest, r = 2.0, x0 = 0, p0 = 2.0.
    localparam longint unsigned ONE_FIX = 64'd1 << FRAC_BITS;
    localparam t_uval RST_PROCESS_NOISE      = t_uval'((ONE_FIX + 64'd5) / 64'd10);
    localparam t_uval RST_MEASUREMENT_NOISE  = t_uval'(ONE_FIX * 64'd2);
    localparam t_sval RST_INITIAL_ESTIMATE   = '0;
    localparam t_uval RST_INITIAL_COVARIANCE = t_uval'(ONE_FIX * 64'd2);

    // Unity gain in Q1.16.
    localparam t_gain GAIN_ONE = t_gain'(1) << GAIN_BITS;

endpackage

>>> rtl/scalar_kalman_filter_top.sv
// Scalar Kalman filter: one predict/update step per measurement transaction.
//
// One-channel, one-dimensional Kalman filter on signed Q16.16 samples. Each
// accepted measurement transaction grows the covariance by q (saturating),
// forms the gain k = p/(p+r) in Q1.16 with round half up, moves the estimate
// by k*(m-x) (rounded half up, saturated to 32 bits) and shrinks the
// covariance to (1-k)*p. The result transaction carries the new estimate, the
// gain used and an error flag; error is set, gain is 0 and the estimate is
// left unchanged when p+q plus r is zero. Setting restart reloads estimate and
// covariance from the initial registers before the step. Each item runs
// through the setup states predict, denominator and divider load, then the
// restoring divider that produces the gain one quotient bit per cycle, then
// the two products, which share one 18x34 multiplier in consecutive cycles,
// and a commit state. The next item is taken the cycle after the commit; a
// zero denominator skips divider and multiplier. The block holds o_stall
// high from acceptance until its result enters the output register, so the
// next item can be taken while that result still waits.
// Configuration writes are always ready and take effect at once; write them
// only while the filter is idle. Several channels are several instances.
module scalar_kalman_filter_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  skf_pkg::t_cfg_idx      i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    // measurement channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [31:0]     i_measurement,
    input  logic                   i_restart,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [31:0]     o_estimate,
    output logic [16:0]            o_gain,
    output logic                   o_error
);
    import skf_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRED = 3'd1; // p1 = sat(p + q), diff = m - x
    localparam logic [2:0] S_DEN  = 3'd2; // den = p1 + r
    localparam logic [2:0] S_LOAD = 3'd3; // zero check, divider setup
    localparam logic [2:0] S_DIV  = 3'd4; // one quotient bit per cycle
    localparam logic [2:0] S_MUL1 = 3'd5; // k * diff
    localparam logic [2:0] S_MUL2 = 3'd6; // new estimate; (1 - k) * p1
    localparam logic [2:0] S_DONE = 3'd7; // commit state, load result

    localparam int DEN_W  = DATA_W + 1;
    localparam int NUM_W  = DATA_W + GAIN_BITS + 1;
    localparam int PROD_W = 52;
    localparam int CNT_W  = $clog2(GAIN_W);

    // configuration registers
    t_uval r_q, r_r, r_p0;
    t_sval r_x0;

    // filter state
    t_sval r_x;
    t_uval r_p;

    logic [2:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [DATA_W-1:0] r_m;
    logic signed [DATA_W:0]  r_diff;
    t_uval                   r_p1;
    logic [DEN_W-1:0]        r_den;
    logic [DEN_W-1:0]        r_rem;
    t_gain                   r_quo;      // dividend low bits shift out, quotient in
    logic                    r_err;
    logic signed [PROD_W-1:0] r_prod;
    t_sval                   r_xn;

    // output register
    logic                    r_out_valid;
    t_sval                   r_out_est;
    t_gain                   r_out_gain;
    logic                    r_out_err;

    logic in_acc;
    logic out_free;
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // predict: saturating p + q
    logic [DATA_W:0] p_sum;
    t_uval           p1_sat;
    assign p_sum  = {1'b0, r_p} + {1'b0, r_q};
    assign p1_sat = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];

    // dividend (p1 << 16) + den/2; its top bits start the remainder
    logic [NUM_W-1:0] num;
    assign num = {1'b0, r_p1, {GAIN_BITS{1'b0}}} + NUM_W'(r_den[DEN_W-1:1]);

    // restoring divider step
    logic [DEN_W:0]   div_t;
    logic             div_ge;
    logic [DEN_W:0]   div_sub;
    assign div_t   = {r_rem, r_quo[GAIN_W-1]};
    assign div_ge  = div_t >= {1'b0, r_den};
    assign div_sub = div_t - {1'b0, r_den};

    // shared multiplier
    logic signed [GAIN_W:0]        mul_a;
    logic signed [DATA_W+1:0]      mul_b;
    logic signed [PROD_W-1:0]      mul_y;
    t_gain                         one_minus_k;
    assign one_minus_k = GAIN_ONE - r_quo;
    always_comb begin
        if (r_state == S_MUL1) begin
            mul_a = $signed({1'b0, r_quo});
            mul_b = {r_diff[DATA_W], r_diff};
        end else begin
            mul_a = $signed({1'b0, one_minus_k});
            mul_b = $signed({2'b00, r_p1});
        end
    end
    assign mul_y = mul_a * mul_b;

    // estimate update, rounded half up, saturated
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (GAIN_BITS - 1);
    logic signed [PROD_W-1:0]      rnd;
    logic signed [PROD_W-GAIN_BITS-1:0] step;
    logic signed [PROD_W-GAIN_BITS:0]   xs;
    t_sval                         xn_sat;
    assign rnd  = r_prod + HALF;
    assign step = rnd[PROD_W-1:GAIN_BITS];
    assign xs   = (PROD_W-GAIN_BITS+1)'(r_x) + (PROD_W-GAIN_BITS+1)'(step);
    localparam logic signed [PROD_W-GAIN_BITS:0] XMAX = (PROD_W-GAIN_BITS+1)'(32'h7fffffff);
    localparam logic signed [PROD_W-GAIN_BITS:0] XMIN = -(XMAX + 1);
    always_comb begin
        priority if (xs > XMAX) begin
            xn_sat = 32'sh7fffffff;
        end else if (xs < XMIN) begin
            xn_sat = 32'sh80000000;
        end else begin
            xn_sat = xs[DATA_W-1:0];
        end
    end

    // covariance update: never exceeds p1, so no saturation
    t_uval pn;
    assign pn = rnd[DATA_W+GAIN_BITS-1:GAIN_BITS];

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_PRED;
            S_PRED: n_state = S_DEN;
            S_DEN:  n_state = S_LOAD;
            S_LOAD: n_state = (r_den == '0) ? S_DONE : S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q  <= RST_PROCESS_NOISE;
            r_r  <= RST_MEASUREMENT_NOISE;
            r_x0 <= RST_INITIAL_ESTIMATE;
            r_p0 <= RST_INITIAL_COVARIANCE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PROCESS_NOISE:      r_q  <= i_cfg_data;
                REG_MEASUREMENT_NOISE:  r_r  <= i_cfg_data;
                REG_INITIAL_ESTIMATE:   r_x0 <= $signed(i_cfg_data);
                REG_INITIAL_COVARIANCE: r_p0 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // filter state: loaded from the initial registers on reset and restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= RST_INITIAL_ESTIMATE;
            r_p <= RST_INITIAL_COVARIANCE;
        end else if (in_acc && i_restart) begin
            r_x <= r_x0;
            r_p <= r_p0;
        end else if (r_state == S_DONE && out_free) begin
            r_x <= r_xn;
            r_p <= r_err ? r_p1 : pn;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) r_m <= i_measurement;
            end
            S_PRED: begin
                r_p1   <= p1_sat;
                r_diff <= {r_m[DATA_W-1], r_m} - {r_x[DATA_W-1], r_x};
            end
            S_DEN: begin
                r_den <= {1'b0, r_p1} + {1'b0, r_r};
            end
            S_LOAD: begin
                r_rem <= {1'b0, num[NUM_W-1:GAIN_W]};
                r_quo <= (r_den == '0) ? '0 : num[GAIN_W-1:0];
                r_err <= (r_den == '0);
                r_xn  <= r_x;
                r_cnt <= CNT_W'(GAIN_W - 1);
            end
            S_DIV: begin
                r_rem <= div_ge ? div_sub[DEN_W-1:0] : div_t[DEN_W-1:0];
                r_quo <= {r_quo[GAIN_W-2:0], div_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_MUL1: begin
                r_prod <= mul_y;
            end
            S_MUL2: begin
                r_xn   <= xn_sat;
                r_prod <= mul_y;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_est  <= r_xn;
            r_out_gain <= r_quo;
            r_out_err  <= r_err;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_estimate  = r_out_est;
    assign o_gain      = r_out_gain;
    assign o_error     = r_out_err;

endmodule

>>> verif/tb_scalar_kalman_filter_top.sv
// Self-checking testbench for scalar_kalman_filter_top: bit-exact prediction, random flow control.
`timescale 1ns / 100ps

module tb_scalar_kalman_filter_top;
    import skf_pkg::*;

    // Run shape
    localparam int RANDOM_PHASES   = 8;
    localparam int SAMPLES_PER_SET = 75;
    localparam int REG_COUNT       = 4;
    localparam int LONG_HOLD       = 400;   // forced receiver hold-off, in cycles
    localparam int HOLD_AFTER      = 60;    // results seen before the forced hold-off
    localparam int DRAIN_CYCLES    = 40;    // wait for stray results before the verdict
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no transaction at all

    localparam longint SVAL_MAX = 64'sd2147483647;
    localparam longint SVAL_MIN = -64'sd2147483648;

    typedef struct packed {
        t_sval measurement;
        logic  restart;
    } t_sample;

    typedef struct packed {
        t_sval estimate;
        t_gain gain;
        logic  error;
    } t_filter_out;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_ALTERNATE,
        STALL_HALF,
        STALL_HEAVY
    } t_stall_mode;

    // DUT connections; every input has a known value from time zero
    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_cfg_valid = 1'b0;
    logic     o_cfg_ready;
    t_cfg_idx i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    logic signed [31:0] i_measurement = '0;
    logic     i_restart = 1'b0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    logic signed [31:0] o_estimate;
    logic [16:0] o_gain;
    logic     o_error;

    // Predictor copy of the configuration registers and of the filter state
    t_uval q_noise = RST_PROCESS_NOISE;
    t_uval r_noise = RST_MEASUREMENT_NOISE;
    t_sval x_init  = RST_INITIAL_ESTIMATE;
    t_uval p_init  = RST_INITIAL_COVARIANCE;
    t_sval x_state = RST_INITIAL_ESTIMATE;
    t_uval p_state = RST_INITIAL_COVARIANCE;

    t_sample     queued_samples[$];
    t_filter_out predicted_outputs[$];
    int unsigned samples_queued = 0;
    int unsigned samples_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_count = 0;

    scalar_kalman_filter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_measurement (i_measurement),
        .i_restart     (i_restart),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_estimate    (o_estimate),
        .o_gain        (o_gain),
        .o_error       (o_error)
    );

    always #2 i_clk = ~i_clk;

    // One predict/update step of the filter. Covariance growth saturates at
    // 32 bits, the gain and both products round half up, the estimate
    // saturates to the signed 32-bit range.
    function automatic t_filter_out kalman_update(input t_sval m, input logic restart);
        longint unsigned p_grown, denom, k, p_next;
        longint          diff, x_next;
        t_filter_out     res;
        if (restart) begin
            x_state = x_init;
            p_state = p_init;
        end
        p_grown = 64'(p_state) + 64'(q_noise);
        if (p_grown > 64'hFFFF_FFFF)
            p_grown = 64'hFFFF_FFFF;
        denom = p_grown + 64'(r_noise);
        if (denom == 0) begin
            // p + r vanished: flag it, keep x, p stays at the grown value (zero)
            p_state      = t_uval'(p_grown);
            res.estimate = x_state;
            res.gain     = '0;
            res.error    = 1'b1;
            return res;
        end
        k = ((p_grown << GAIN_BITS) + (denom >> 1)) / denom;
        if (k > 64'(GAIN_ONE))
            k = 64'(GAIN_ONE);
        diff   = longint'(m) - longint'(x_state);
        x_next = longint'(x_state)
               + ((longint'(k) * diff + (longint'(1) <<< (GAIN_BITS - 1))) >>> GAIN_BITS);
        if (x_next > SVAL_MAX)
            x_next = SVAL_MAX;
        if (x_next < SVAL_MIN)
            x_next = SVAL_MIN;
        p_next = ((64'(GAIN_ONE) - k) * p_grown + (64'd1 << (GAIN_BITS - 1))) >> GAIN_BITS;
        x_state      = t_sval'(x_next);
        p_state      = t_uval'(p_next);
        res.estimate = x_state;
        res.gain     = t_gain'(k);
        res.error    = 1'b0;
        return res;
    endfunction

    function automatic void queue_sample(input t_sval m, input logic restart);
        t_sample s;
        s.measurement = m;
        s.restart     = restart;
        queued_samples.push_back(s);
        samples_queued++;
    endfunction

    // Noise and covariance values: mostly realistic, sometimes the extremes
    function automatic t_uval pick_unsigned_reg();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return '1;
            7, 8: return t_uval'($urandom_range(1, 1 << 24));
            9: return t_uval'($urandom);
            default: return t_uval'($urandom_range(1, 1 << 18));
        endcase
    endfunction

    function automatic t_sval pick_start_estimate();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0: return t_sval'(32'h8000_0000);
            1: return t_sval'(32'h7FFF_FFFF);
            2: return t_sval'($urandom);
            default: return t_sval'(int'($urandom_range(0, 32'd131072000)) - 65536000);
        endcase
    endfunction

    // Config transaction; the predictor copy changes only when it is taken
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            REG_PROCESS_NOISE:      q_noise = value;
            REG_MEASUREMENT_NOISE:  r_noise = value;
            REG_INITIAL_ESTIMATE:   x_init  = t_sval'(value);
            REG_INITIAL_COVARIANCE: p_init  = value;
            default: ;  // unused index, block ignores it
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // Every queued sample taken and every predicted result returned
    task automatic wait_idle();
        while (samples_accepted != samples_queued || predicted_outputs.size() != 0)
            @(posedge i_clk);
    endtask

    // Sample driver: bursts of random length separated by random gaps.
    // The payload only moves when the current transaction is taken or
    // nothing is offered; the prediction runs on the taken transaction.
    always @(posedge i_clk) begin : sample_driver
        t_sample     next_sample;
        int unsigned burst_left;
        int unsigned gap_left;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end else begin
            if (i_valid && !o_stall) begin
                predicted_outputs.push_back(kalman_update(i_measurement, i_restart));
                samples_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (queued_samples.size() != 0) begin
                    next_sample   = queued_samples.pop_front();
                    i_valid       <= 1'b1;
                    i_measurement <= next_sample.measurement;
                    i_restart     <= next_sample.restart;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        // a third of the bursts run straight into the next
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result checker and receiver flow control. Stall follows a pattern that
    // changes at random intervals; once, after HOLD_AFTER results, the
    // receiver holds off for a stretch set by LONG_HOLD so the filter backs up onto
    // its input while the driver keeps offering samples.
    always @(posedge i_clk) begin : result_monitor
        t_filter_out want;
        t_stall_mode stall_mode;
        int unsigned pattern_left;
        int unsigned hold_left;
        bit          forced_hold_done;
        if (!i_rst_n) begin
            i_stall          <= 1'b0;
            stall_mode       = STALL_NONE;
            pattern_left     = 0;
            hold_left        = 0;
            forced_hold_done = 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (predicted_outputs.size() == 0) begin
                    $error("result transaction with no prediction pending");
                    mismatch_count++;
                end else begin
                    want = predicted_outputs.pop_front();
                    if (o_estimate !== want.estimate) begin
                        $error("estimate: expected %0d, got %0d", want.estimate, o_estimate);
                        mismatch_count++;
                    end
                    if (o_gain !== want.gain) begin
                        $error("gain: expected %0d, got %0d", want.gain, o_gain);
                        mismatch_count++;
                    end
                    if (o_error !== want.error) begin
                        $error("error: expected %0b, got %0b", want.error, o_error);
                        mismatch_count++;
                    end
                end
            end

            if (!forced_hold_done && results_seen >= HOLD_AFTER) begin
                forced_hold_done = 1'b1;
                hold_left        = LONG_HOLD;
            end else if (hold_left == 0 && $urandom_range(0, 2999) == 0) begin
                hold_left = $urandom_range(100, 300);
            end

            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (pattern_left == 0) begin
                    stall_mode   = t_stall_mode'($urandom_range(0, 3));
                    pattern_left = $urandom_range(16, 128);
                end else begin
                    pattern_left--;
                end
                case (stall_mode)
                    STALL_NONE:      i_stall <= 1'b0;
                    STALL_ALTERNATE: i_stall <= ~i_stall;
                    STALL_HALF:      i_stall <= ($urandom_range(0, 1) == 0);
                    STALL_HEAVY:     i_stall <= ($urandom_range(0, 9) != 0);
                    default:         i_stall <= 1'b0;
                endcase
            end
        end
    end

    // Ends a hung run: no config, sample or result transaction for too long
    always @(posedge i_clk) begin : watchdog
        int unsigned quiet_cycles;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((i_valid && !o_stall) || (o_valid && !i_stall)
                     || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin : stimulus
        int    truth;
        int    amp;
        t_sval m;
        logic  restart;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: zero, both extremes, all-ones, restart
        queue_sample(t_sval'(0), 1'b0);
        queue_sample(t_sval'(32'h7FFF_FFFF), 1'b0);
        queue_sample(t_sval'(32'h8000_0000), 1'b0);
        queue_sample(t_sval'(-1), 1'b0);
        queue_sample(t_sval'(5 << FRAC_BITS), 1'b1);
        wait_idle();

        // q = r = p0 = 0: p + r is zero, error flagged and x held, twice in
        // a row since p stays zero. An unused register index is ignored.
        write_reg(REG_PROCESS_NOISE, '0);
        write_reg(REG_MEASUREMENT_NOISE, '0);
        write_reg(REG_INITIAL_COVARIANCE, '0);
        write_reg(REG_INITIAL_ESTIMATE, 32'h1234_5678);
        write_reg(t_cfg_idx'(REG_COUNT), 32'hFFFF_FFFF);
        queue_sample(t_sval'(7 << FRAC_BITS), 1'b1);
        queue_sample(t_sval'(32'h8000_0000), 1'b0);
        wait_idle();

        // r = 0 with p > 0: unity gain, estimate jumps across the full range,
        // then p collapses to zero and the next step flags an error
        write_reg(REG_INITIAL_COVARIANCE, 32'd1);
        write_reg(REG_INITIAL_ESTIMATE, 32'h7FFF_FFFF);
        queue_sample(t_sval'(32'h8000_0000), 1'b1);
        queue_sample(t_sval'(32'h7FFF_FFFF), 1'b0);
        wait_idle();

        // Everything at the top: p + q saturates, gain near one half
        write_reg(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
        write_reg(REG_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
        write_reg(REG_INITIAL_COVARIANCE, 32'hFFFF_FFFF);
        write_reg(REG_INITIAL_ESTIMATE, 32'h8000_0000);
        queue_sample(t_sval'(32'h7FFF_FFFF), 1'b1);
        queue_sample(t_sval'(32'h7FFF_FFFF), 1'b0);
        queue_sample(t_sval'(-1), 1'b0);
        queue_sample(t_sval'(0), 1'b1);
        wait_idle();

        // p = q = 0 against a huge r: zero gain, estimate unchanged
        write_reg(REG_PROCESS_NOISE, '0);
        write_reg(REG_INITIAL_COVARIANCE, '0);
        write_reg(REG_INITIAL_ESTIMATE, 32'hFFFF_FFFF);
        queue_sample(t_sval'(32'h7FFF_FFFF), 1'b1);
        queue_sample(t_sval'(123), 1'b0);
        wait_idle();

        // Tiny r: gain close to one
        write_reg(REG_PROCESS_NOISE, RST_PROCESS_NOISE);
        write_reg(REG_MEASUREMENT_NOISE, 32'd1);
        write_reg(REG_INITIAL_COVARIANCE, RST_INITIAL_COVARIANCE);
        write_reg(REG_INITIAL_ESTIMATE, RST_INITIAL_ESTIMATE);
        queue_sample(t_sval'(-(3 << FRAC_BITS)), 1'b1);
        queue_sample(t_sval'(3 << FRAC_BITS), 1'b0);
        queue_sample(t_sval'(1), 1'b0);
        wait_idle();

        // Random settings; samples mostly track a slowly noisy true value,
        // the rest are arbitrary words, with an occasional restart
        for (int set_no = 0; set_no < RANDOM_PHASES; set_no++) begin
            write_reg(REG_PROCESS_NOISE, pick_unsigned_reg());
            write_reg(REG_MEASUREMENT_NOISE, pick_unsigned_reg());
            write_reg(REG_INITIAL_ESTIMATE, pick_start_estimate());
            write_reg(REG_INITIAL_COVARIANCE, pick_unsigned_reg());
            if ($urandom_range(0, 2) == 0)
                write_reg(t_cfg_idx'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
                          $urandom);
            truth = int'($urandom_range(0, 32'd131072000)) - 65536000;
            amp   = 1 << $urandom_range(4, 20);
            for (int n = 0; n < SAMPLES_PER_SET; n++) begin
                if ($urandom_range(0, 99) < 15)
                    m = t_sval'($urandom);
                else
                    m = t_sval'(truth + int'($urandom_range(0, 2 * amp)) - amp);
                restart = ($urandom_range(0, 24) == 0);
                queue_sample(m, restart);
            end
            wait_idle();
        end

        // Let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
